>>> rtl/core/vector_angle_degrees_unit_macros.svh
// assertion helpers used by the checker file vad_checker.sv
`ifndef VECTOR_ANGLE_DEGREES_UNIT_MACROS_SVH
`define VECTOR_ANGLE_DEGREES_UNIT_MACROS_SVH

// implication checked on every clk edge, off while reset is low
`define VAD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vad implication failed");

// condition must hold at every clk edge outside reset
`define VAD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("vad invariant failed");

`endif

>>> rtl/core/vad_pkg.sv
`timescale 1ns / 1ps
package vad_pkg;

	localparam int XY_W    = 16;            // input component width
	localparam int MAG_W   = XY_W + 1;      // magnitude of a component
	localparam int FRAC_W  = 16;            // fraction bits in the rotation datapath
	localparam int CW      = 36;            // rotation datapath width (signed)
	localparam int ANG_W   = 22;            // table entry width
	localparam int ZW      = 25;            // angle accumulator width (signed)
	localparam int ZC_W    = 23;            // clamped angle width
	localparam int RND_SH  = 8;             // 2^-16 degree down to 2^-8 degree
	localparam int TW      = 15;            // first-quadrant angle width
	localparam int HW      = 17;            // heading width
	localparam int ATAN_LEN = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [ZC_W-1:0]     Z90    = ZC_W'(90 * 65536);
	localparam logic [ZC_W:0]       RND_HALF = (ZC_W+1)'(1 << (RND_SH - 1));
	localparam logic signed [HW-1:0] DEG90  = HW'(23040);
	localparam logic signed [HW-1:0] DEG180 = HW'(46080);

	// vector classes, decided at entry
	localparam logic [2:0] CLS_NORM  = 3'd0;
	localparam logic [2:0] CLS_ZERO  = 3'd1;
	localparam logic [2:0] CLS_180   = 3'd2;
	localparam logic [2:0] CLS_POS90 = 3'd3;
	localparam logic [2:0] CLS_NEG90 = 3'd4;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [ZW-1:0] z;
		logic [2:0]           cls;
		logic                 x_neg;
		logic                 y_neg;
	} cordic_t;

	function automatic int run_stages(input int n);
		return (n < ATAN_LEN) ? n : ATAN_LEN;
	endfunction

	// atan(2^-i) in degrees, scaled by 65536
	function automatic logic [ANG_W-1:0] atan_q16(input int idx);
		logic [ANG_W-1:0] v;
		case (idx)
			0:  v = 22'd2949120;
			1:  v = 22'd1740967;
			2:  v = 22'd919879;
			3:  v = 22'd466945;
			4:  v = 22'd234379;
			5:  v = 22'd117304;
			6:  v = 22'd58666;
			7:  v = 22'd29335;
			8:  v = 22'd14668;
			9:  v = 22'd7334;
			10: v = 22'd3667;
			11: v = 22'd1833;
			12: v = 22'd917;
			13: v = 22'd458;
			14: v = 22'd229;
			15: v = 22'd115;
			16: v = 22'd57;
			17: v = 22'd29;
			18: v = 22'd14;
			19: v = 22'd7;
			20: v = 22'd4;
			21: v = 22'd2;
			22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/vad_cordic_stage.sv
`timescale 1ns / 1ps
module vad_cordic_stage #(
	parameter int STAGE = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	input  vad_pkg::cordic_t d_in,
	output logic             vld_out,
	output vad_pkg::cordic_t d_out
);
	import vad_pkg::*;

	localparam logic signed [ZW-1:0] ANG = ZW'(atan_q16(STAGE));

	logic             vld_s1;
	cordic_t          cord_s1;
	cordic_t          nxt;
	logic signed [CW-1:0] sh_a;
	logic signed [CW-1:0] sh_b;

	always_comb begin
		sh_a = d_in.a >>> STAGE;
		sh_b = d_in.b >>> STAGE;
		nxt  = d_in;
		// rotate toward the a axis, direction from the sign of b
		if (!d_in.b[CW-1]) begin
			nxt.a = d_in.a + sh_b;
			nxt.b = d_in.b - sh_a;
			nxt.z = d_in.z + ANG;
		end else begin
			nxt.a = d_in.a - sh_b;
			nxt.b = d_in.b + sh_a;
			nxt.z = d_in.z - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		cord_s1 <= nxt;
	end

	assign vld_out = vld_s1;
	assign d_out   = cord_s1;

endmodule

>>> rtl/core/vector_angle_degrees_unit.sv
`timescale 1ns / 1ps
// channel   | handshake           | payload
// ----------+---------------------+------------------------------
// input     | start high, busy low | stick_x[15:0], stick_y[15:0]
// result    | done strobe, 1 cycle | heading[16:0]
//
// one vector accepted every cycle; busy never rises
// the path runs through the entry register, one register per rotation
// stage, the round register and the quadrant/output register
// reset clears only the valid bits; payload registers are not reset
// results cannot be held off, so the pipeline never stalls
module vector_angle_degrees_unit #(
	parameter int CORDIC_STAGES = vad_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [vad_pkg::XY_W-1:0] stick_x,
	input  logic signed [vad_pkg::XY_W-1:0] stick_y,
	output logic                          done,
	output logic signed [vad_pkg::HW-1:0] heading
);
	import vad_pkg::*;

	localparam int N_RUN = run_stages(CORDIC_STAGES);

	// entry stage
	logic              x_neg;
	logic              y_neg;
	logic              x_zero;
	logic              y_zero;
	logic signed [MAG_W-1:0] xs;
	logic signed [MAG_W-1:0] ys;
	logic [MAG_W-1:0]  ax;
	logic [MAG_W-1:0]  ay;
	cordic_t           ent;
	logic              vld_s1;
	cordic_t           ent_s1;

	logic              chain_vld [0:N_RUN];
	cordic_t           chain_d   [0:N_RUN];

	// round stage
	cordic_t           fin;
	logic [ZC_W-1:0]   zc;
	logic [ZC_W:0]     zr;
	logic              vld_s2;
	logic [TW-1:0]     t_s2;
	logic [2:0]        cls_s2;
	logic              x_neg_s2;
	logic              y_neg_s2;

	// quadrant stage
	logic signed [HW-1:0] mag;
	logic signed [HW-1:0] hd;
	logic              vld_s3;
	logic signed [HW-1:0] heading_s3;

	always_comb begin
		x_neg  = stick_x[XY_W-1];
		y_neg  = stick_y[XY_W-1];
		x_zero = (stick_x == '0);
		y_zero = (stick_y == '0);
		xs     = {stick_x[XY_W-1], stick_x};
		ys     = {stick_y[XY_W-1], stick_y};
		ax     = x_neg ? MAG_W'(-xs) : MAG_W'(xs);
		ay     = y_neg ? MAG_W'(-ys) : MAG_W'(ys);
		ent.a  = CW'({ay, {FRAC_W{1'b0}}});
		ent.b  = CW'({ax, {FRAC_W{1'b0}}});
		ent.z  = '0;
		ent.x_neg = x_neg;
		ent.y_neg = y_neg;
		if (x_zero && y_zero) begin
			ent.cls = CLS_ZERO;
		end else if (x_zero) begin
			ent.cls = y_neg ? CLS_180 : CLS_ZERO;
		end else if (y_zero) begin
			ent.cls = x_neg ? CLS_NEG90 : CLS_POS90;
		end else begin
			ent.cls = CLS_NORM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= ent;
	end

	assign chain_vld[0] = vld_s1;
	assign chain_d[0]   = ent_s1;

	for (genvar i = 0; i < N_RUN; i++) begin : g_rot
		vad_cordic_stage #(
			.STAGE (i)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (chain_vld[i]),
			.d_in    (chain_d[i]),
			.vld_out (chain_vld[i+1]),
			.d_out   (chain_d[i+1])
		);
	end

	// clamp to [0, 90 deg] then round to 1/256 degree
	always_comb begin
		fin = chain_d[N_RUN];
		if (fin.z[ZW-1]) begin
			zc = '0;
		end else if (fin.z > $signed({{(ZW-ZC_W){1'b0}}, Z90})) begin
			zc = Z90;
		end else begin
			zc = fin.z[ZC_W-1:0];
		end
		zr = {1'b0, zc} + RND_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= chain_vld[N_RUN];
		end
	end

	always_ff @(posedge clk) begin
		t_s2     <= TW'(zr >> RND_SH);
		cls_s2   <= fin.cls;
		x_neg_s2 <= fin.x_neg;
		y_neg_s2 <= fin.y_neg;
	end

	// quadrant placement and axis cases
	always_comb begin
		mag = y_neg_s2 ? (DEG180 - $signed({2'b00, t_s2})) : $signed({2'b00, t_s2});
		case (cls_s2)
			CLS_NORM:  hd = x_neg_s2 ? -mag : mag;
			CLS_ZERO:  hd = '0;
			CLS_180:   hd = DEG180;
			CLS_POS90: hd = DEG90;
			CLS_NEG90: hd = -DEG90;
			default:   hd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		heading_s3 <= hd;
	end

	assign busy    = 1'b0;
	assign done    = vld_s3;
	assign heading = heading_s3;

endmodule

>>> rtl/core/vad_checker.sv
`timescale 1ns / 1ps
`include "vector_angle_degrees_unit_macros.svh"
module vad_checker #(
	parameter int CORDIC_STAGES = vad_pkg::CORDIC_STAGES_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic signed [vad_pkg::XY_W-1:0] stick_x,
	input logic signed [vad_pkg::XY_W-1:0] stick_y,
	input logic                          done,
	input logic signed [vad_pkg::HW-1:0] heading
);
	import vad_pkg::*;

	localparam int LAT = run_stages(CORDIC_STAGES) + 3;

	// every accepted transaction comes back after a fixed latency
	`VAD_ASSERT_IMP(a_lat_fwd, start && !busy, ##LAT done)
	// no result without a transaction accepted exactly that long ago
	`VAD_ASSERT_IMP(a_lat_bwd, done, $past(start && !busy, LAT))
	// heading stays within plus/minus 180 degrees
	`VAD_ASSERT_IMP(a_range, done, (heading <= DEG180) && (heading >= -DEG180))
	// origin and y axis give their fixed headings, sign taken from the accepted y
	`VAD_ASSERT_IMP(a_axis, start && !busy && (stick_x == '0), ##LAT (($past(stick_y[XY_W-1], LAT) && heading == DEG180) || (!$past(stick_y[XY_W-1], LAT) && heading == '0)))

endmodule

bind vector_angle_degrees_unit vad_checker #(
	.CORDIC_STAGES (CORDIC_STAGES)
) u_vad_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.stick_x (stick_x),
	.stick_y (stick_y),
	.done    (done),
	.heading (heading)
);
